// File: sv/cubic_overdrive_with_dc_block_assert.svh
`ifndef CUBIC_OVERDRIVE_WITH_DC_BLOCK_ASSERT_SVH
`define CUBIC_OVERDRIVE_WITH_DC_BLOCK_ASSERT_SVH

// Checked at every rising edge outside reset.
`define COD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define COD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cod_pkg.sv
package cod_pkg;

	localparam int unsigned SAMPLE_BITS      = 24;
	localparam int unsigned FRAC             = SAMPLE_BITS - 1;
	localparam int unsigned FILT_BITS        = SAMPLE_BITS + 8;
	localparam int unsigned CHAN_BITS        = 3;
	localparam int unsigned CHAN_SLOTS       = 1 << CHAN_BITS;
	localparam int unsigned MAX_CHANNELS_DEF = 8;

	localparam int unsigned GAIN_BITS   = 33;
	localparam int unsigned GAIN_FRAC   = 16;
	localparam int unsigned COLOUR_BITS = 23;

	localparam int unsigned COEF_BITS = 20;
	localparam int unsigned COEF_0995 = 1043333;

	// floor(n/3) == (n * RECIP3) >> RECIP3_SHIFT for all n up to 2^FRAC
	localparam int unsigned RECIP3_SHIFT = FRAC + 2;
	localparam int unsigned RECIP3       = ((1 << RECIP3_SHIFT) + 2) / 3;

	// shared multiplier: signed operands wide enough for the filter state
	localparam int unsigned MUL_W  = FILT_BITS + 1;
	localparam int unsigned PROD_W = 2 * MUL_W;

	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE_GAIN    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COLOUR_OFFSET = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE        = 2'd2;

	localparam logic [GAIN_BITS-1:0]   DRIVE_GAIN_RST    = 33'd655360;
	localparam logic [COLOUR_BITS-1:0] COLOUR_OFFSET_RST = 23'd838861;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic [CHAN_BITS-1:0]          channel;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic [CHAN_BITS-1:0]          channel_out;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAIN_HI,
		ST_GAIN_LO,
		ST_CLAMP,
		ST_SQUARE,
		ST_CUBE,
		ST_DIV3,
		ST_SHAPE,
		ST_FILT,
		ST_MIX
	} state_t;

endpackage

// File: sv/cod_mul.sv
module cod_mul #(
	parameter int unsigned W = cod_pkg::MUL_W
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	import cod_pkg::*;

	logic signed [2*W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

	assign p = p_q;

endmodule

// File: sv/cubic_overdrive_with_dc_block.sv
// Cubic soft-clip overdrive with a per-channel DC blocker.
//
// Input channel (in_valid / in_stall / in_data): one signed Q1.23 sample and
// its channel number per transfer. Output channel (out_valid / out_stall /
// out_data): one processed sample per input, with the same channel number.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): drive gain,
// colour offset and enable at indexes 0..2; index 3 is ignored. cfg_ready is
// always high; write only while no sample is in flight.
//
// One 33x33 multiplier is shared by a ten-state sequencer: gain (two
// halves), blocker coefficient, square, cube and divide by three each take
// one pass. A new input is taken only while the sequencer is idle, so one
// sample is processed at a time. Bypassed samples (effect off or channel
// out of range) go from the idle state straight to the last step.
//
// The result sits in an output register; the next input is taken while it
// waits. If out_stall holds the register full when the next result is
// ready, the sequencer waits in its last step. Reset clears the filter
// state of all channels, restores the register defaults and empties the
// output register.
`include "cubic_overdrive_with_dc_block_assert.svh"

module cubic_overdrive_with_dc_block #(
	parameter int unsigned MAX_CHANNELS = cod_pkg::MAX_CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cod_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output cod_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cod_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [cod_pkg::GAIN_BITS-1:0]      cfg_data
);
	import cod_pkg::*;

	localparam int unsigned STATE_DEPTH = (MAX_CHANNELS < CHAN_SLOTS) ? MAX_CHANNELS : CHAN_SLOTS;
	localparam int unsigned IDX_W       = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
	localparam int unsigned GHI_W       = GAIN_BITS - GAIN_FRAC;
	localparam int unsigned M_W         = SAMPLE_BITS + GAIN_FRAC + 1;
	localparam int unsigned T_W         = M_W + 2;
	localparam int unsigned V_W         = SAMPLE_BITS + 1;
	localparam int unsigned SUM_W       = FILT_BITS + 2;
	localparam int unsigned MIX_W       = FILT_BITS + 3;

	localparam logic signed [T_W-1:0]   LIM   = T_W'(1) <<< (FRAC + GAIN_FRAC);
	localparam logic signed [V_W-1:0]   V_ONE = V_W'(1) <<< FRAC;
	localparam logic [SAMPLE_BITS-1:0]  AM_ONE = SAMPLE_BITS'(1) << FRAC;
	localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'((64'sd1 <<< (FILT_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] Y_MIN = -Y_MAX - SUM_W'(1);
	localparam logic signed [MIX_W-1:0] O_MAX = MIX_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [MIX_W-1:0] O_MIN = -O_MAX - MIX_W'(1);
	localparam logic signed [SAMPLE_BITS-1:0] S_BOUND =
		SAMPLE_BITS'((1 << FRAC) - (1 << FRAC) / 3);

	state_t state_q, state_d;

	logic [GAIN_BITS-1:0]   gain_q;
	logic [COLOUR_BITS-1:0] colour_q;
	logic                   enable_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [CHAN_BITS-1:0]          ch_q;
	logic                          pass_q;
	logic [SAMPLE_BITS-1:0]        hi_q;
	logic                          sat_q;
	logic [SAMPLE_BITS-1:0]        am_q;
	logic                          vneg_q;
	logic signed [FILT_BITS-1:0]   yd_q;
	logic signed [SAMPLE_BITS-1:0] s_q;
	logic signed [FILT_BITS-1:0]   y_q;
	logic signed [SAMPLE_BITS-1:0] ps_q [STATE_DEPTH];
	logic signed [FILT_BITS-1:0]   pf_q [STATE_DEPTH];
	out_item_t                     out_q;
	logic                          out_valid_q;

	logic                   accept_in, bypass_in, load_out;
	logic [IDX_W-1:0]       idx;
	logic [SAMPLE_BITS-1:0] ax;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	logic [M_W-1:0]                m_w;
	logic signed [T_W-1:0]         m_s, t_w, t_sh;
	logic signed [V_W-1:0]         v_c, v_abs;
	logic [SAMPLE_BITS-1:0]        a_slice;
	logic [FRAC-1:0]               q3;
	logic [SAMPLE_BITS-1:0]        sm;
	logic signed [PROD_W-1:0]      prod_rnd;
	logic signed [SUM_W-1:0]       y_sum;
	logic signed [FILT_BITS-1:0]   y_c;
	logic signed [MIX_W-1:0]       mix_sum, mix_sh;
	logic signed [SAMPLE_BITS-1:0] o_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign bypass_in = !enable_q || (32'(in_data.channel) >= MAX_CHANNELS);
	assign idx       = ch_q[IDX_W-1:0];
	assign ax        = x_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_q) : SAMPLE_BITS'(x_q);
	assign a_slice   = prod[2*FRAC:FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= DRIVE_GAIN_RST;
			colour_q <= COLOUR_OFFSET_RST;
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DRIVE_GAIN:    gain_q   <= cfg_data;
				CFG_COLOUR_OFFSET: colour_q <= cfg_data[COLOUR_BITS-1:0];
				CFG_ENABLE:        enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mul_a    = '0;
		mul_b    = '0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = bypass_in ? ST_MIX : ST_GAIN_HI;
			end
			ST_GAIN_HI: begin
				mul_a   = {{(MUL_W-SAMPLE_BITS){1'b0}}, ax};
				mul_b   = {{(MUL_W-GHI_W){1'b0}}, gain_q[GAIN_BITS-1:GAIN_FRAC]};
				state_d = ST_GAIN_LO;
			end
			ST_GAIN_LO: begin
				mul_a   = {{(MUL_W-SAMPLE_BITS){1'b0}}, ax};
				mul_b   = {{(MUL_W-GAIN_FRAC){1'b0}}, gain_q[GAIN_FRAC-1:0]};
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				mul_a   = MUL_W'(pf_q[idx]);
				mul_b   = MUL_W'(COEF_0995);
				state_d = ST_SQUARE;
			end
			ST_SQUARE: begin
				mul_a   = {{(MUL_W-SAMPLE_BITS){1'b0}}, am_q};
				mul_b   = {{(MUL_W-SAMPLE_BITS){1'b0}}, am_q};
				state_d = ST_CUBE;
			end
			ST_CUBE: begin
				mul_a   = {{(MUL_W-SAMPLE_BITS){1'b0}}, am_q};
				mul_b   = {{(MUL_W-SAMPLE_BITS){1'b0}}, a_slice};
				state_d = ST_DIV3;
			end
			ST_DIV3: begin
				mul_a   = {{(MUL_W-SAMPLE_BITS){1'b0}}, a_slice};
				mul_b   = MUL_W'(RECIP3);
				state_d = ST_SHAPE;
			end
			ST_SHAPE: state_d = ST_FILT;
			ST_FILT:  state_d = ST_MIX;
			ST_MIX: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	cod_mul #(
		.W(MUL_W)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	// gain, offset and clamp
	always_comb begin
		m_w  = M_W'({hi_q, {GAIN_FRAC{1'b0}}}) + M_W'(prod[M_W-2:0]);
		m_s  = $signed({2'b00, m_w});
		t_w  = (x_q[SAMPLE_BITS-1] ? -m_s : m_s) + $signed(T_W'({colour_q, {GAIN_FRAC{1'b0}}}));
		t_sh = t_w >>> GAIN_FRAC;
		priority if (sat_q) v_c = x_q[SAMPLE_BITS-1] ? -V_ONE : V_ONE;
		else if (t_w >= LIM) v_c = V_ONE;
		else if (t_w <= -LIM) v_c = -V_ONE;
		else v_c = t_sh[V_W-1:0];
		v_abs = v_c[V_W-1] ? -v_c : v_c;
	end

	// shaping, blocker and mix
	always_comb begin
		prod_rnd = prod + (PROD_W'(1) <<< (COEF_BITS - 1));
		q3       = prod[RECIP3_SHIFT +: FRAC];
		sm       = am_q - {1'b0, q3};
		y_sum    = SUM_W'(s_q) - SUM_W'(ps_q[idx]) + SUM_W'(yd_q);
		priority if (y_sum > Y_MAX) y_c = Y_MAX[FILT_BITS-1:0];
		else if (y_sum < Y_MIN) y_c = Y_MIN[FILT_BITS-1:0];
		else y_c = y_sum[FILT_BITS-1:0];
		mix_sum  = (MIX_W'(x_q) <<< 1) + (MIX_W'(y_q) <<< 1) + MIX_W'(y_q);
		mix_sh   = mix_sum >>> 2;
		priority if (mix_sh > O_MAX) o_c = O_MAX[SAMPLE_BITS-1:0];
		else if (mix_sh < O_MIN) o_c = O_MIN[SAMPLE_BITS-1:0];
		else o_c = mix_sh[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			x_q    <= in_data.sample_in;
			ch_q   <= in_data.channel;
			pass_q <= bypass_in;
		end
		if (state_q == ST_GAIN_LO) begin
			sat_q <= |prod[PROD_W-1:SAMPLE_BITS];
			hi_q  <= prod[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_CLAMP) begin
			am_q   <= v_abs[SAMPLE_BITS-1:0];
			vneg_q <= v_c[V_W-1];
		end
		if (state_q == ST_SQUARE) begin
			yd_q <= prod_rnd[COEF_BITS +: FILT_BITS];
		end
		if (state_q == ST_SHAPE) begin
			s_q <= vneg_q ? -$signed(sm) : $signed(sm);
		end
		if (state_q == ST_FILT) begin
			y_q <= y_c;
		end
		if (load_out) begin
			out_q.sample_out  <= pass_q ? x_q : o_c;
			out_q.channel_out <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STATE_DEPTH; i++) begin
				ps_q[i] <= '0;
				pf_q[i] <= '0;
			end
		end else if (state_q == ST_FILT) begin
			ps_q[idx] <= s_q;
			pf_q[idx] <= y_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`COD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")
	`COD_ASSERT(a_out_from_mix, $rose(out_valid_q) |-> $past(state_q == ST_MIX), "output loaded outside mix step")
	`COD_ASSERT(a_clamp_range, (state_q == ST_SQUARE) |-> (am_q <= AM_ONE), "clamped magnitude above one")
	`COD_ASSERT(a_shape_range, (state_q == ST_FILT) |-> (s_q <= S_BOUND && s_q >= -S_BOUND), "shaped value out of range")

endmodule

// File: bench/overdrive_check.sv
`timescale 1ns / 100ps

module overdrive_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  cod_pkg::in_item_t                  in_data,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  cod_pkg::out_item_t                 out_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [cod_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [cod_pkg::GAIN_BITS-1:0]      cfg_data,
	output int                                 mismatches,
	output int                                 in_flight
);
	import cod_pkg::*;

	localparam int     NUM_CH     = MAX_CHANNELS_DEF;
	localparam longint BLOCK_COEF = COEF_0995;
	localparam int     REPORT_MAX = 10;

	longint gain_q16;
	longint colour_q23;
	bit     fx_on;
	longint shaped_hist [NUM_CH];
	longint filt_hist [NUM_CH];
	out_item_t pending_samples [$];

	function automatic longint clip_to(longint v, int w);
		longint hi;
		hi = (longint'(1) << (w - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// Predict one output sample and advance the channel's blocker history.
	function automatic out_item_t shape_and_block(in_item_t it);
		longint one, x, ax, m, t, v, am, a2, a3, s, y, o;
		bit neg;
		int ch;
		out_item_t r;
		one = longint'(1) << FRAC;
		x = longint'($signed(it.sample_in));
		ch = it.channel;
		r.channel_out = it.channel;
		r.sample_out = it.sample_in;
		if (!fx_on || ch >= NUM_CH)
			return r;

		neg = x < 0;
		ax = neg ? -x : x;
		// the integer part of the gain alone already pushes past full scale
		if ((gain_q16 >> GAIN_FRAC) != 0 &&
				ax * (gain_q16 >> GAIN_FRAC) >= (longint'(1) << (FRAC + 1))) begin
			v = neg ? -one : one;
		end else begin
			m = ax * gain_q16;
			t = (neg ? -m : m) + (colour_q23 << (FRAC - 7));
			if (t >= (one << GAIN_FRAC))
				v = one;
			else if (t <= -(one << GAIN_FRAC))
				v = -one;
			else
				v = t >>> GAIN_FRAC;
		end

		am = v < 0 ? -v : v;
		a2 = (am * am) >> FRAC;
		a3 = (am * a2) >> FRAC;
		s = am - a3 / 3;
		if (v < 0)
			s = -s;

		y = (filt_hist[ch] * BLOCK_COEF + (longint'(1) << (COEF_BITS - 1))) >>> COEF_BITS;
		y = clip_to(s - shaped_hist[ch] + y, FILT_BITS);
		shaped_hist[ch] = s;
		filt_hist[ch] = y;

		o = clip_to((2 * x + 3 * y) >>> 2, SAMPLE_BITS);
		r.sample_out = o[SAMPLE_BITS-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			gain_q16 = longint'(DRIVE_GAIN_RST);
			colour_q23 = longint'(COLOUR_OFFSET_RST);
			fx_on = 1'b1;
			foreach (shaped_hist[i]) begin
				shaped_hist[i] = 0;
				filt_hist[i] = 0;
			end
			pending_samples.delete();
			mismatches = 0;
			in_flight = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_DRIVE_GAIN: gain_q16 = longint'(cfg_data);
				CFG_COLOUR_OFFSET: colour_q23 = longint'(cfg_data[COLOUR_BITS-1:0]);
				CFG_ENABLE: fx_on = cfg_data[0];
				default: ;
				endcase
			end
			// retire the oldest expectation before adding this edge's new one
			if (out_valid && !out_stall) begin
				if (pending_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected transfer: sample %0d channel %0d", $realtime,
							out_data.sample_out, out_data.channel_out);
				end else begin
					want = pending_samples.pop_front();
					if (out_data.sample_out !== want.sample_out ||
							out_data.channel_out !== want.channel_out) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: mismatch: expected sample %0d channel %0d, got %0d %0d",
								$realtime, want.sample_out, want.channel_out,
								out_data.sample_out, out_data.channel_out);
					end
				end
			end
			if (in_valid && !in_stall)
				pending_samples.push_back(shape_and_block(in_data));
			in_flight = pending_samples.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import cod_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED  = 2'd3;
	localparam logic [GAIN_BITS-1:0]    GAIN_MAX    = 33'd6553600000;
	localparam logic [COLOUR_BITS-1:0]  COLOUR_MAX  = 23'd4194304;
	localparam logic [SAMPLE_BITS-1:0]  SMP_MAX     = 24'h7FFFFF;
	localparam logic [SAMPLE_BITS-1:0]  SMP_MIN     = 24'h800000;
	localparam logic [SAMPLE_BITS-1:0]  SMP_NEG_ONE = 24'hFFFFFF;
	localparam int IDLE_LIMIT  = 5000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [GAIN_BITS-1:0] cfg_data;

	int mismatches;
	int in_flight;
	int idle_cycles = 0;
	int stall_left;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	bit stall_quiet = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	cubic_overdrive_with_dc_block dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	overdrive_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// mostly short idle runs, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [GAIN_BITS-1:0] rand_gain();
		logic [GAIN_BITS-1:0] g;
		int unsigned r;
		r = $urandom_range(0, 9);
		g = {$urandom_range(0, 1) == 1, $urandom()};
		if (g > GAIN_MAX)
			g = g - 33'h1_0000_0000;
		if (r == 0)
			return '0;
		if (r == 1)
			return GAIN_MAX;
		if (r <= 4)
			return GAIN_BITS'($urandom_range(0, 1 << 18));
		if (r <= 7)
			return GAIN_BITS'($urandom_range(0, 1 << 22));
		return g;
	endfunction

	function automatic logic [COLOUR_BITS-1:0] rand_colour();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return COLOUR_MAX;
		return COLOUR_BITS'($urandom_range(0, COLOUR_MAX));
	endfunction

	// full-scale noise, quiet signals, extremes and sign flips of the last sample
	function automatic logic [SAMPLE_BITS-1:0] rand_sample(logic [SAMPLE_BITS-1:0] prev);
		int v;
		int unsigned r;
		r = $urandom_range(0, 99);
		v = $urandom();
		if (r < 35)
			return v[SAMPLE_BITS-1:0];
		if (r < 55) begin
			v = v >>> $urandom_range(8, 30);
			return v[SAMPLE_BITS-1:0];
		end
		if (r < 70) begin
			case ($urandom_range(0, 4))
			0: return SMP_MAX;
			1: return SMP_MIN;
			2: return '0;
			3: return SAMPLE_BITS'(1);
			default: return SMP_NEG_ONE;
			endcase
		end
		return ~prev + 1'b1;
	endfunction

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp,
			input logic [CHAN_BITS-1:0] ch, input int gap);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{sample_in: smp, channel: ch};
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait for every predicted sample to come back
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [GAIN_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (stall_quiet || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left = idle_len() - 1;
			end
		end
	end

	initial begin : stimulus
		logic [SAMPLE_BITS-1:0] smp;
		logic [CHAN_BITS-1:0] ch;
		bit quiet;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		smp = '0;
		ch = '0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// register defaults, every channel, full-scale and tiny inputs
		send_sample(SMP_MAX, 3'd0, 0);
		send_sample(SMP_MIN, 3'd1, 0);
		send_sample('0, 3'd2, 0);
		send_sample(24'd1, 3'd3, 0);
		send_sample(SMP_NEG_ONE, 3'd4, 0);
		send_sample(24'h400000, 3'd5, 0);
		send_sample(24'hC00000, 3'd6, 0);
		send_sample(24'd12345, 3'd7, 0);
		settle();

		// no gain: only the colour offset reaches the shaper
		write_reg(CFG_DRIVE_GAIN, '0);
		write_reg(CFG_COLOUR_OFFSET, GAIN_BITS'(COLOUR_MAX));
		send_sample(SMP_MAX, 3'd0, 0);
		send_sample(SMP_MIN, 3'd0, 0);
		settle();

		// largest gain, hard clipping; alternate signs to drive the mix into saturation
		write_reg(CFG_DRIVE_GAIN, GAIN_MAX);
		write_reg(CFG_COLOUR_OFFSET, '0);
		send_sample(SMP_MAX, 3'd1, 0);
		send_sample(SMP_MIN, 3'd1, 0);
		send_sample(SMP_MAX, 3'd1, 0);
		send_sample(SMP_MIN, 3'd1, 0);
		send_sample(24'd1, 3'd2, 0);
		send_sample(SMP_NEG_ONE, 3'd2, 0);
		settle();

		// unity gain puts the negative extreme exactly on the lower clamp bound, the positive one just below the upper
		write_reg(CFG_DRIVE_GAIN, 33'd65536);
		send_sample(SMP_MIN, 3'd3, 0);
		send_sample(SMP_MAX, 3'd3, 0);
		settle();

		// a write to the unused index must change nothing; then bypass
		write_reg(CFG_UNUSED, 33'h1_FFFF_FFFF);
		write_reg(CFG_ENABLE, '0);
		send_sample(SMP_MIN, 3'd4, 0);
		send_sample(SMP_MAX, 3'd5, 0);
		send_sample(24'd777, 3'd6, 0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_DRIVE_GAIN, rand_gain());
			write_reg(CFG_COLOUR_OFFSET, GAIN_BITS'(rand_colour()));
			write_reg(CFG_ENABLE, GAIN_BITS'($urandom_range(0, 4) != 0));
			// phase 2 fills the block behind a long output hold-off, phase 5 runs flat out
			quiet = (p == 2) || (p == 5);
			stall_quiet = (p == 5);
			hold_req = (p == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				smp = rand_sample(smp);
				if ($urandom_range(0, 9) >= 3)
					ch = CHAN_BITS'($urandom_range(0, 7));
				send_sample(smp, ch,
					(!quiet && $urandom_range(0, 2) == 0) ? idle_len() : 0);
			end
			settle();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && in_flight == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/cod_pkg.sv
sv/cod_mul.sv
sv/cubic_overdrive_with_dc_block.sv
bench/overdrive_check.sv
bench/tb.sv
